@@ hw/rtl/irpdm_pkg.sv @@
package irpdm_pkg;

    localparam int unsigned HZ_W       = 18;
    localparam int unsigned DUTY_W     = 9;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned CYC_W      = 14;
    localparam int unsigned TIME_W     = 7;
    localparam int unsigned PERIOD_W   = 23;
    localparam int unsigned DIV_NW     = 36;
    localparam int unsigned DIV_DW     = 24;
    localparam int unsigned DIV_CNT_W  = 6;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [HZ_W-1:0]   HZ_MIN         = 18'd10000;
    localparam logic [HZ_W-1:0]   HZ_MAX         = 18'd200000;
    localparam logic [DUTY_W-1:0] DUTY_FULL      = 9'd256;
    localparam logic [CYC_W-1:0]  CYCLES_MAX     = 14'd16383;
    localparam logic [DIV_NW-1:0] US_Q16         = 36'd65536000000;
    localparam logic [32:0]       ROUND_HALF_Q24 = 33'd8388608;
    localparam logic [7:0]        CHAR_ZERO      = 8'h30;
    localparam logic [7:0]        CHAR_ONE       = 8'h31;

    localparam logic [HZ_W-1:0]   RST_CARRIER_HZ   = 18'd38000;
    localparam logic [DUTY_W-1:0] RST_DUTY         = 9'd128;
    localparam logic [DUR_W-1:0]  RST_LEADER_MARK  = 16'd9000;
    localparam logic [DUR_W-1:0]  RST_LEADER_SPACE = 16'd4500;
    localparam logic [DUR_W-1:0]  RST_ONE_MARK     = 16'd562;
    localparam logic [DUR_W-1:0]  RST_ZERO_MARK    = 16'd562;
    localparam logic [DUR_W-1:0]  RST_ONE_SPACE    = 16'd1688;
    localparam logic [DUR_W-1:0]  RST_ZERO_SPACE   = 16'd562;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_HZ   = 3'd0,
        CFG_DUTY         = 3'd1,
        CFG_LEADER_MARK  = 3'd2,
        CFG_LEADER_SPACE = 3'd3,
        CFG_ONE_MARK     = 3'd4,
        CFG_ZERO_MARK    = 3'd5,
        CFG_ONE_SPACE    = 3'd6,
        CFG_ZERO_SPACE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LEADER = 2'd0,
        MODE_CHAR   = 2'd1,
        MODE_TRAIL  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PDIV,
        BK_DUTY,
        BK_CDIV,
        BK_GAP
    } t_back_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] code_char;
    } t_req;

    typedef struct packed {
        logic              is_mark;
        logic [CYC_W-1:0]  carrier_cycles;
        logic [TIME_W-1:0] high_us;
        logic [TIME_W-1:0] low_us;
        logic [DUR_W-1:0]  gap_us;
        logic              last;
    } t_res;

    typedef struct packed {
        logic             has_gap;
        logic [DUR_W-1:0] mark_us;
        logic [DUR_W-1:0] gap_us;
    } t_job;

    typedef struct packed {
        logic              req;
        logic [HZ_W-1:0]   carrier_hz;
        logic [DUTY_W-1:0] duty;
    } t_param;

endpackage

@@ hw/rtl/irpdm_queue.sv @@
module irpdm_queue #(
    parameter int unsigned QUEUE_DEPTH = irpdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  irpdm_pkg::t_job   i_push_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output irpdm_pkg::t_job   o_head
);
    import irpdm_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

endmodule

@@ hw/rtl/irpdm_div.sv @@
module irpdm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [irpdm_pkg::DIV_NW-1:0]  i_num,
    input  logic [irpdm_pkg::DIV_DW-1:0]  i_den,
    output logic                          o_done,
    output logic [irpdm_pkg::DIV_NW-1:0]  o_quot
);
    import irpdm_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NW-1:0]    r_quo;
    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_DW-1:0]    r_den;
    logic [DIV_DW:0]      trial;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    assign trial  = {r_rem, r_quo[DIV_NW-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == DIV_CNT_W'(DIV_NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
        end
    end

endmodule

@@ hw/rtl/irpdm_front.sv @@
module irpdm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  irpdm_pkg::t_req                  i_req,
    input  logic                             i_cfg_valid,
    input  logic [irpdm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpdm_pkg::HZ_W-1:0]       i_cfg_data,
    input  logic                             i_param_take,
    output irpdm_pkg::t_param                o_param,
    output logic                             o_push,
    output irpdm_pkg::t_job                  o_push_job,
    input  logic                             i_full
);
    import irpdm_pkg::*;

    logic [HZ_W-1:0]   r_carrier_hz;
    logic [DUTY_W-1:0] r_duty;
    logic [DUR_W-1:0]  r_leader_mark;
    logic [DUR_W-1:0]  r_leader_space;
    logic [DUR_W-1:0]  r_one_mark;
    logic [DUR_W-1:0]  r_zero_mark;
    logic [DUR_W-1:0]  r_one_space;
    logic [DUR_W-1:0]  r_zero_space;
    logic              r_dirty, n_dirty;
    logic              job_ok;
    t_job              job;

    assign o_busy = i_full;

    // map request to a mark/gap pair (trail: mark only)
    always_comb begin
        job_ok = 1'b0;
        job    = '0;
        case (t_mode'(i_req.mode))
            MODE_LEADER: begin
                job_ok = 1'b1;
                job    = '{has_gap: 1'b1, mark_us: r_leader_mark, gap_us: r_leader_space};
            end
            MODE_CHAR: begin
                if (i_req.code_char == CHAR_ZERO) begin
                    job_ok = 1'b1;
                    job    = '{has_gap: 1'b1, mark_us: r_zero_mark, gap_us: r_zero_space};
                end else if (i_req.code_char == CHAR_ONE) begin
                    job_ok = 1'b1;
                    job    = '{has_gap: 1'b1, mark_us: r_one_mark, gap_us: r_one_space};
                end
            end
            MODE_TRAIL: begin
                job_ok = 1'b1;
                job    = '{has_gap: 1'b0, mark_us: r_one_mark, gap_us: '0};
            end
            default: begin
                job_ok = 1'b0;
            end
        endcase
    end

    assign o_push     = i_start && !i_full && job_ok;
    assign o_push_job = job;

    assign o_param = '{req: r_dirty, carrier_hz: r_carrier_hz, duty: r_duty};

    always_comb begin
        n_dirty = r_dirty;
        if (i_param_take) begin
            n_dirty = 1'b0;
        end
        if (i_cfg_valid && (i_cfg_index == CFG_CARRIER_HZ || i_cfg_index == CFG_DUTY)) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty        <= 1'b1;
            r_carrier_hz   <= RST_CARRIER_HZ;
            r_duty         <= RST_DUTY;
            r_leader_mark  <= RST_LEADER_MARK;
            r_leader_space <= RST_LEADER_SPACE;
            r_one_mark     <= RST_ONE_MARK;
            r_zero_mark    <= RST_ZERO_MARK;
            r_one_space    <= RST_ONE_SPACE;
            r_zero_space   <= RST_ZERO_SPACE;
        end else begin
            r_dirty <= n_dirty;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CARRIER_HZ:   r_carrier_hz   <= i_cfg_data;
                    CFG_DUTY:         r_duty         <= i_cfg_data[DUTY_W-1:0];
                    CFG_LEADER_MARK:  r_leader_mark  <= i_cfg_data[DUR_W-1:0];
                    CFG_LEADER_SPACE: r_leader_space <= i_cfg_data[DUR_W-1:0];
                    CFG_ONE_MARK:     r_one_mark     <= i_cfg_data[DUR_W-1:0];
                    CFG_ZERO_MARK:    r_zero_mark    <= i_cfg_data[DUR_W-1:0];
                    CFG_ONE_SPACE:    r_one_space    <= i_cfg_data[DUR_W-1:0];
                    CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data[DUR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/irpdm_back.sv @@
module irpdm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irpdm_pkg::t_param  i_param,
    output logic               o_param_take,
    input  logic               i_empty,
    input  irpdm_pkg::t_job    i_head,
    output logic               o_pop,
    output logic               o_res_valid,
    output irpdm_pkg::t_res    o_res
);
    import irpdm_pkg::*;

    t_back_state         r_state, n_state;
    logic                r_res_valid, n_res_valid;
    t_res                r_res, n_res;
    t_job                r_job, n_job;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [TIME_W-1:0]   r_high, n_high;
    logic [TIME_W-1:0]   r_low, n_low;

    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic                div_done;
    logic [DIV_NW-1:0]   div_quot;

    logic [HZ_W-1:0]     hz_c;
    logic [DUTY_W-1:0]   duty_c;
    logic [32:0]         prod_hi;
    logic [32:0]         prod_lo;
    logic [CYC_W-1:0]    cycles;

    irpdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign hz_c = (i_param.carrier_hz < HZ_MIN) ? HZ_MIN :
                  (i_param.carrier_hz > HZ_MAX) ? HZ_MAX : i_param.carrier_hz;
    assign duty_c = (i_param.duty > DUTY_FULL) ? DUTY_FULL : i_param.duty;

    assign prod_hi = 33'(r_period) * 33'(duty_c) + ROUND_HALF_Q24;
    assign prod_lo = 33'(r_period) * 33'(DUTY_FULL - duty_c) + ROUND_HALF_Q24;

    assign cycles = (div_quot > DIV_NW'(CYCLES_MAX)) ? CYCLES_MAX : div_quot[CYC_W-1:0];

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state      = r_state;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        n_job        = r_job;
        n_period     = r_period;
        n_high       = r_high;
        n_low        = r_low;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        o_param_take = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_param.req) begin
                    // period = round(1e6 * 2^16 / f)
                    o_param_take = 1'b1;
                    div_start    = 1'b1;
                    div_num      = US_Q16 + DIV_NW'(hz_c >> 1);
                    div_den      = DIV_DW'(hz_c);
                    n_state      = BK_PDIV;
                end else if (!i_empty) begin
                    // cycles = round(dur / period)
                    o_pop     = 1'b1;
                    n_job     = i_head;
                    div_start = 1'b1;
                    div_num   = DIV_NW'({i_head.mark_us, 17'd0}) + DIV_NW'(r_period);
                    div_den   = {r_period, 1'b0};
                    n_state   = BK_CDIV;
                end
            end
            BK_PDIV: begin
                if (div_done) begin
                    n_period = div_quot[PERIOD_W-1:0];
                    n_state  = BK_DUTY;
                end
            end
            BK_DUTY: begin
                n_high  = prod_hi[30:24];
                n_low   = prod_lo[30:24];
                n_state = BK_IDLE;
            end
            BK_CDIV: begin
                if (div_done) begin
                    n_res_valid = 1'b1;
                    n_res       = '{is_mark: 1'b1, carrier_cycles: cycles, high_us: r_high,
                                    low_us: r_low, gap_us: '0, last: !r_job.has_gap};
                    n_state     = r_job.has_gap ? BK_GAP : BK_IDLE;
                end
            end
            BK_GAP: begin
                n_res_valid = 1'b1;
                n_res       = '{is_mark: 1'b0, carrier_cycles: '0, high_us: '0,
                                low_us: '0, gap_us: r_job.gap_us, last: 1'b1};
                n_state     = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_job    <= n_job;
        r_period <= n_period;
        r_high   <= n_high;
        r_low    <= n_low;
    end

endmodule

@@ hw/rtl/ir_pulse_distance_modulator.sv @@
// channel   | signals                                   | transfer
// ----------+-------------------------------------------+-------------------------------
// request   | i_start, o_busy, i_req                    | i_start & !o_busy
// result    | o_res_valid, o_res                        | o_res_valid, one cycle each
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | i_cfg_valid & o_cfg_ready
//           | i_cfg_data                                |
//
// Requests enter one per cycle while the job queue has room; o_busy means queue full.
// Each mark is sized by the back end's 36-step divider after a load; a gap follows as its own result.
// After reset and after a carrier or duty write, the period is recomputed first.
// Synchronous active-low reset; results cannot be stalled.
module ir_pulse_distance_modulator #(
    parameter int unsigned QUEUE_DEPTH = irpdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  irpdm_pkg::t_req                  i_req,
    output logic                             o_res_valid,
    output irpdm_pkg::t_res                  o_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [irpdm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpdm_pkg::HZ_W-1:0]       i_cfg_data
);
    import irpdm_pkg::*;

    t_param param;
    logic   param_take;
    logic   push;
    t_job   push_job;
    logic   full;
    logic   pop;
    logic   empty;
    t_job   head;

    assign o_cfg_ready = 1'b1;

    irpdm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req        (i_req),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_param_take (param_take),
        .o_param      (param),
        .o_push       (push),
        .o_push_job   (push_job),
        .i_full       (full)
    );

    irpdm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head)
    );

    irpdm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_param      (param),
        .o_param_take (param_take),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res)
    );

endmodule
